// File: rtl/chs_pkg.sv
// ============================================================================
// chs_pkg
// Shared widths, defaults and register map of the cumulative histogram scaler.
// ============================================================================
package chs_pkg;

    // Default table size and stored count width.
    localparam int BINS_DEFAULT        = 256;
    localparam int COUNT_WIDTH_DEFAULT = 24;

    // Fixed field widths.
    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 8;
    localparam int LEVELS_W = 17;
    localparam int OUT_W    = 16;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_LEVELS = 1'b0;

    // Reset value of the levels register.
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 17'd256;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

    // Largest value that fits the result field.
    localparam logic [LEVELS_W-1:0] OUT_MAX = 17'd65535;

endpackage

// File: rtl/cumulative_histogram_scaler.sv
// ============================================================================
// cumulative_histogram_scaler
// Stores a cumulative histogram and returns its equalization transfer values.
// ============================================================================
// Loads are accepted back to back. A read stalls the input until its result
// issues, after two bin-store reads, a multiply and a COUNT_WIDTH+18 step
// restoring divide, or with no reads and no divide when the bin gives 0
// outright. A stalled result holds the input. Reset clears the load pointer,
// the total and the first nonzero bin; the bin store itself is not cleared
// and holds nothing until it is loaded.
module cumulative_histogram_scaler #(
    parameter int BINS        = chs_pkg::BINS_DEFAULT,
    parameter int COUNT_WIDTH = chs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [chs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [chs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [chs_pkg::OPCODE_W-1:0]      opcode,
    input  logic [COUNT_WIDTH-1:0]            bin_count,
    input  logic [chs_pkg::INDEX_W-1:0]       bin_index,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [chs_pkg::OUT_W-1:0]         scaled_level
);

    import chs_pkg::*;

    localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int FNZ_W = $clog2(BINS + 1);
    localparam int EXT_W = (FNZ_W > INDEX_W) ? FNZ_W : INDEX_W;
    localparam int SUM_W = COUNT_WIDTH + 1;
    localparam int DEN_W = COUNT_WIDTH + 1;
    localparam int NUM_W = SUM_W + LEVELS_W;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [FNZ_W-1:0] FNZ_NONE = FNZ_W'(BINS);
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_PREV,
        ST_MUL,
        ST_DIV,
        ST_SAT
    } state_t;

    // Control registers.
    state_t                state_reg, state_next;
    logic [LEVELS_W-1:0]   levels_reg, levels_next;
    logic [IDX_W-1:0]      load_ptr_reg, load_ptr_next;
    logic [FNZ_W-1:0]      fnz_reg, fnz_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      scaled_level_reg, scaled_level_next;

    // Datapath registers.
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  first_reg, first_next;
    logic                  zero_reg, zero_next;
    logic [COUNT_WIDTH-1:0] cur_reg, cur_next;
    logic [NUM_W-1:0]      dq_reg, dq_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // Bin store.
    logic [COUNT_WIDTH-1:0] bin_store [BINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mem_we;

    // Helper signals.
    logic                   in_accept;
    logic                   cfg_write;
    logic                   can_emit;
    logic [EXT_W-1:0]       idx_wide;
    logic [SUM_W-1:0]       pair_sum;
    logic [DEN_W:0]         trial;
    logic [LEVELS_W-1:0]    sat_level;

    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite;
    assign can_emit  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign scaled_level = scaled_level_reg;

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LEVELS)
        begin
            prdata = APB_DATA_W'(levels_reg);
        end
    end

    // Store addressing: the current bin first, then the bin below it (or the same bin for the first nonzero bin).
    assign mem_we   = in_accept && (opcode == OP_LOAD);
    assign rd_addr  = (state_reg == ST_PREV && !first_reg) ? idx_reg - 1'b1 : idx_reg;
    assign idx_wide = EXT_W'(bin_index);
    assign pair_sum = {1'b0, rd_data_reg} + {1'b0, cur_reg};
    assign trial    = {rem_reg, dq_reg[NUM_W-1]};

    // Saturate the quotient at levels-1 and at the output range.
    always_comb
    begin
        sat_level = '0;
        if (!zero_reg)
        begin
            if (dq_reg >= NUM_W'(levels_reg))
            begin
                sat_level = levels_reg - 1'b1;
            end
            else
            begin
                sat_level = dq_reg[LEVELS_W-1:0];
            end
            if (sat_level > OUT_MAX)
            begin
                sat_level = OUT_MAX;
            end
        end
    end

    // Next-state and datapath logic.
    always_comb
    begin
        state_next        = state_reg;
        levels_next       = levels_reg;
        load_ptr_next     = load_ptr_reg;
        fnz_next          = fnz_reg;
        total_next        = total_reg;
        out_valid_next    = out_valid_reg;
        scaled_level_next = scaled_level_reg;
        idx_next          = idx_reg;
        first_next        = first_reg;
        zero_next         = zero_reg;
        cur_next          = cur_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        cnt_next          = cnt_reg;

        if (cfg_write && paddr[2] == REG_LEVELS)
        begin
            levels_next = pwdata[LEVELS_W-1:0];
        end

        // A result beat leaves when the sink takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && opcode == OP_LOAD)
                begin
                    // Track the first nonzero bin and the total of the table.
                    if (load_ptr_reg == '0)
                    begin
                        fnz_next = (bin_count != '0) ? '0 : FNZ_NONE;
                    end
                    else if (bin_count != '0 && fnz_reg == FNZ_NONE)
                    begin
                        fnz_next = FNZ_W'(load_ptr_reg);
                    end
                    if (load_ptr_reg == LAST_BIN)
                    begin
                        total_next    = bin_count;
                        load_ptr_next = '0;
                    end
                    else
                    begin
                        load_ptr_next = load_ptr_reg + 1'b1;
                    end
                end
                else if (in_accept)
                begin
                    idx_next   = idx_wide[IDX_W-1:0];
                    first_next = (idx_wide == EXT_W'(fnz_reg));
                    if (levels_reg == '0 || fnz_reg == FNZ_NONE ||
                        idx_wide >= EXT_W'(BINS) || idx_wide < EXT_W'(fnz_reg))
                    begin
                        zero_next  = 1'b1;
                        dq_next    = '0;
                        state_next = ST_SAT;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        state_next = ST_CUR;
                    end
                end
            end
            ST_CUR:
            begin
                state_next = ST_PREV;
            end
            ST_PREV:
            begin
                cur_next   = rd_data_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // Numerator and divisor of the scaled level.
                dq_next    = NUM_W'(pair_sum) * NUM_W'(levels_reg);
                den_next   = (total_reg == '0) ? DEN_W'(2) : {total_reg, 1'b0};
                rem_next   = '0;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // One restoring division step per cycle.
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = DEN_W'(trial - {1'b0, den_reg});
                    dq_next  = {dq_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DEN_W-1:0];
                    dq_next  = {dq_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (can_emit)
                begin
                    scaled_level_next = sat_level[OUT_W-1:0];
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            levels_reg       <= LEVELS_RESET;
            load_ptr_reg     <= '0;
            fnz_reg          <= FNZ_NONE;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
            scaled_level_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            levels_reg       <= levels_next;
            load_ptr_reg     <= load_ptr_next;
            fnz_reg          <= fnz_next;
            total_reg        <= total_next;
            out_valid_reg    <= out_valid_next;
            scaled_level_reg <= scaled_level_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        zero_reg  <= zero_next;
        cur_reg   <= cur_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
    end

    // Bin store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_store[load_ptr_reg] <= bin_count;
        end
        rd_data_reg <= bin_store[rd_addr];
    end

endmodule

// File: tb/sv/testbench.sv
// ============================================================================
// testbench
// Checks the cumulative histogram scaler: a short table of directed beats,
// then three random tables loaded bin by bin with reads mixed in, all
// compared against typed values or an in-bench model of the transfer-table arithmetic.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import chs_pkg::*;

    localparam int BINS        = BINS_DEFAULT;
    localparam int CW          = COUNT_WIDTH_DEFAULT;
    // Drain time: a read's full latency with a margin on top of it.
    localparam int DRAIN_CYCLES = CW + 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [CW-1:0] COUNT_MAX = '1;

    typedef enum int {ROW_LOAD, ROW_READ, ROW_LEVELS} row_kind_t;
    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_t;

    typedef struct {
        row_kind_t         kind;
        logic [CW-1:0]     count;
        logic [INDEX_W-1:0] index;
        logic [31:0]       levels;
        bit                known;
        logic [OUT_W-1:0]  level;
    } dir_row_t;

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [OPCODE_W-1:0] opcode;
    logic [CW-1:0] bin_count;
    logic [INDEX_W-1:0] bin_index;
    logic [OUT_W-1:0] scaled_level;

    // Model of the block state.
    logic [CW-1:0]       hist_bins [BINS];
    bit                  bin_loaded [BINS];
    int                  fill_ptr;
    int                  first_hit;
    logic [CW-1:0]       table_total;
    logic [LEVELS_W-1:0] gray_levels;

    // Expected scaled levels, oldest first.
    logic [OUT_W-1:0] level_queue [$];
    logic [OUT_W-1:0] want_level;
    int errors = 0;
    int cycle_count;
    idle_t idle_mode = IDLE_LIGHT;
    int stall_left = 0;
    dir_row_t dir_rows [$];

    cumulative_histogram_scaler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .bin_count    (bin_count),
        .bin_index    (bin_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scaled_level (scaled_level)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Scaled transfer value of one bin from the current table state.
    function automatic logic [OUT_W-1:0] scale_level_of(input logic [INDEX_W-1:0] idx);
        logic [63:0] cur, prev, num, den, q;
        if (gray_levels == 0 || first_hit >= BINS || int'(idx) < first_hit)
            return '0;
        cur  = 64'(hist_bins[idx]);
        prev = (int'(idx) == first_hit) ? cur : 64'(hist_bins[idx - 1]);
        num  = (prev + cur) * 64'(gray_levels);
        den  = 2 * 64'(table_total);
        if (den < 2)
            den = 2;
        q = num / den;
        if (q >= 64'(gray_levels))
            q = 64'(gray_levels) - 1;
        if (q > 64'(OUT_MAX))
            q = 64'(OUT_MAX);
        return q[OUT_W-1:0];
    endfunction

    // One load beat: store the count and track first nonzero bin and total.
    function automatic void store_count(input logic [CW-1:0] cnt);
        if (fill_ptr == 0)
            first_hit = BINS;
        hist_bins[fill_ptr]  = cnt;
        bin_loaded[fill_ptr] = 1'b1;
        if (cnt != 0 && first_hit >= BINS)
            first_hit = fill_ptr;
        if (fill_ptr == BINS - 1)
            table_total = cnt;
        fill_ptr = (fill_ptr + 1) % BINS;
    endfunction

    // A read must never touch a bin that was not loaded since reset.
    function automatic bit bin_ready(input int idx);
        if (first_hit >= BINS || idx < first_hit)
            return 1'b1;
        if (idx == first_hit)
            return bin_loaded[idx];
        return bin_loaded[idx] && bin_loaded[idx - 1];
    endfunction

    function automatic dir_row_t mk_row(input row_kind_t kind, input logic [CW-1:0] cnt,
                                        input int idx, input logic [31:0] lv,
                                        input bit known, input int level);
        dir_row_t r;
        r.kind   = kind;
        r.count  = cnt;
        r.index  = idx[INDEX_W-1:0];
        r.levels = lv;
        r.known  = known;
        r.level  = level[OUT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        if (idle_mode == IDLE_NONE)
            return 0;
        if ($urandom_range(0, idle_mode == IDLE_LIGHT ? 9 : 2) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    // Present one beat and hold it until accepted, then update the model.
    task automatic drive_beat(input logic [OPCODE_W-1:0] op, input logic [CW-1:0] cnt,
                              input logic [INDEX_W-1:0] idx, input bit known,
                              input logic [OUT_W-1:0] typed);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        bin_count = cnt;
        bin_index = idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_READ)
            level_queue.push_back(known ? typed : scale_level_of(idx));
        else
            store_count(cnt);
    endtask

    // Drop valid and let every pending read and any load in flight finish.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (level_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the levels register while idle, then read it back.
    task automatic write_levels(input logic [31:0] value);
        drain();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_LEVELS, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[LEVELS_W-1:0] !== value[LEVELS_W-1:0])
        begin
            $display("%0t: levels readback expected %0d actual %0d",
                     $time, value[LEVELS_W-1:0], prdata[LEVELS_W-1:0]);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        gray_levels = value[LEVELS_W-1:0];
    endtask

    // Random read, biased toward the edges of the nonzero region.
    task automatic read_random();
        int idx;
        int tries;
        case ($urandom_range(0, 7))
            0: idx = (first_hit < BINS) ? first_hit : 0;
            1: idx = (first_hit > 0 && first_hit < BINS) ? first_hit - 1 : BINS - 1;
            2: idx = BINS - 1;
            3: idx = 0;
            default: idx = $urandom_range(0, BINS - 1);
        endcase
        tries = 0;
        while (!bin_ready(idx) && tries < 64)
        begin
            idx = $urandom_range(0, BINS - 1);
            tries++;
        end
        if (!bin_ready(idx))
            idx = 0;
        drive_beat(OP_READ, CW'($urandom), idx[INDEX_W-1:0], 1'b0, '0);
    endtask

    // Output side: random stall bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_mode != IDLE_NONE &&
                 $urandom_range(0, idle_mode == IDLE_LIGHT ? 9 : 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (level_queue.size() == 0)
            begin
                $display("%0t: expected no result, actual scaled_level %0d",
                         $time, scaled_level);
                errors++;
            end
            else
            begin
                want_level = level_queue.pop_front();
                if (scaled_level !== want_level)
                begin
                    $display("%0t: scaled_level expected %0d actual %0d",
                             $time, want_level, scaled_level);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus.
    initial
    begin
        logic [CW-1:0] vals [BINS];
        longint cum;
        int lead, step, b, n_reads;
        logic [31:0] lv;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        opcode    = OP_LOAD;
        bin_count = '0;
        bin_index = '0;
        out_stall = 1'b0;

        fill_ptr    = 0;
        first_hit   = BINS;
        table_total = '0;
        gray_levels = LEVELS_RESET;
        foreach (bin_loaded[i])
            bin_loaded[i] = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, partial table with total still zero,
        // count extremes, a falling count, and levels at its extremes.
        dir_rows.push_back(mk_row(ROW_READ, '0, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, BINS - 1, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_LOAD, '0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LOAD, '0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LOAD, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LOAD, COUNT_MAX, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LOAD, 5, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 1, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 2, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 3, 0, 1, 255));
        dir_rows.push_back(mk_row(ROW_READ, '0, 4, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LEVELS, '0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 3, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_LEVELS, '0, 0, 1, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 3, 0, 1, 0));
        dir_rows.push_back(mk_row(ROW_LEVELS, '0, 0, 65536, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 3, 0, 1, 65535));
        dir_rows.push_back(mk_row(ROW_READ, '0, 4, 0, 0, 0));
        dir_rows.push_back(mk_row(ROW_LEVELS, '0, 0, 131071, 0, 0));
        dir_rows.push_back(mk_row(ROW_READ, '0, 3, 0, 1, 65535));
        dir_rows.push_back(mk_row(ROW_LEVELS, '0, 0, 256, 0, 0));

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_LEVELS: write_levels(dir_rows[i].levels);
                ROW_LOAD:   drive_beat(OP_LOAD, dir_rows[i].count, INDEX_W'($urandom),
                                       1'b0, '0);
                default:    drive_beat(OP_READ, CW'($urandom), dir_rows[i].index,
                                       dir_rows[i].known, dir_rows[i].level);
            endcase
        end

        // Random part: three full tables, each under its own levels setting.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_mode = idle_t'($urandom_range(0, 2));
            case (ph)
                0: lv = $urandom_range(1, 65536);
                1: lv = $urandom_range(2, 300);
                default: lv = 32'd1 << $urandom_range(0, 16);
            endcase
            write_levels(lv);

            // Cumulative counts with leading zeros and occasional outliers.
            lead = (ph == 1) ? $urandom_range(0, BINS) : $urandom_range(0, 40);
            case ($urandom_range(0, 2))
                0: step = 3;
                1: step = 1000;
                default: step = 65535;
            endcase
            cum = 0;
            for (b = 0; b < BINS; b++)
            begin
                if (b >= lead)
                    cum += $urandom_range(0, step);
                if (cum > longint'(COUNT_MAX))
                    cum = longint'(COUNT_MAX);
                if (b >= lead && $urandom_range(0, 29) == 0)
                    vals[b] = CW'($urandom_range(0, 32'h00FF_FFFF));
                else
                    vals[b] = cum[CW-1:0];
            end
            if (ph == 2)
                vals[BINS - 1] = COUNT_MAX;

            // Load in pointer order up to the wrap, so that the next table
            // starts at bin 0, with reads of the partial table mixed in.
            do
            begin
                if ($urandom_range(0, 9) == 0)
                    read_random();
                drive_beat(OP_LOAD, vals[fill_ptr], INDEX_W'($urandom), 1'b0, '0);
            end
            while (fill_ptr != 0);

            // Reads of the complete table; the final stretch runs without idling.
            n_reads = 70;
            if (ph == 2)
                idle_mode = IDLE_NONE;
            for (int r = 0; r < n_reads; r++)
                read_random();
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: cumulative_histogram_scaler.f
rtl/chs_pkg.sv
rtl/cumulative_histogram_scaler.sv
tb/sv/testbench.sv
